@@ src/sha_pkg.sv @@
// Shared types and constants for the SHA-256 message hasher.
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Datapath word-load selection.
  typedef enum logic [1:0] {
    LD_MSG   = 2'd0,
    LD_PAD   = 2'd1,
    LD_ZERO  = 2'd2,
    LD_LEN   = 2'd3
  } ld_sel_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic    init;      // chaining value := IV, length := 0
    logic    load;      // write one word into the block store
    ld_sel_t ld_sel;
    logic    len_add;   // add 8*nbytes to the bit length
    logic    start;     // copy chaining value into working vars
    logic    round;     // one compression round
    logic    fold;      // chaining value += working vars
    logic    rehash;    // second pass: block store words 0..7 := digest
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [3:0] widx;   // next word slot in the block
    logic [5:0] rnd;    // round counter
  } sts_t;

endpackage

@@ src/sha_if.sv @@
// Valid/ready channel interfaces for message and digest items.
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, data_word, valid_bytes, last_word, input ready);
  modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

@@ src/sha_dp.sv @@
// SHA-256 datapath: block store, message schedule, round unit, chaining value.
module sha_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sha_pkg::cmd_t      cmd,
  input  logic [31:0]        in_word,
  input  logic [2:0]         in_nb,
  input  logic [2:0]         rd_idx,
  output logic [31:0]        rd_word,
  output sha_pkg::sts_t      sts
);

  localparam logic [7:0] PAD_BYTE_W = sha_pkg::PAD_BYTE;

  sha_pkg::word_t w_r [16];
  sha_pkg::word_t h_r [8];
  sha_pkg::word_t v_r [8];
  logic [63:0] len_r;
  logic [3:0]  widx_r;
  logic [5:0]  rnd_r;

  logic [31:0] msg_word, ld_word, wt, s0, s1, wnew;
  logic [31:0] t1, t2, ch, mj, e, a, se, sa;
  logic [2:0]  nb;

  always_comb begin
    nb = (in_nb > 3'd4) ? 3'd4 : in_nb;
    unique case (nb)
      3'd0:    msg_word = {PAD_BYTE_W, 24'h0};
      3'd1:    msg_word = {in_word[31:24], PAD_BYTE_W, 16'h0};
      3'd2:    msg_word = {in_word[31:16], PAD_BYTE_W, 8'h0};
      3'd3:    msg_word = {in_word[31:8], PAD_BYTE_W};
      default: msg_word = in_word;
    endcase
    case (cmd.ld_sel)
      sha_pkg::LD_MSG:  ld_word = msg_word;
      sha_pkg::LD_PAD:  ld_word = {PAD_BYTE_W, 24'h0};
      sha_pkg::LD_ZERO: ld_word = 32'h0;
      default:          ld_word = (widx_r == 4'd14) ? len_r[63:32] : len_r[31:0];
    endcase
  end

  // Rolling 16-word schedule: w_r[0] is W[t].
  always_comb begin
    wt = w_r[0];
    s0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
       ^ (w_r[14] >> 10);
    wnew = s1 + w_r[9] + s0 + w_r[0];
    a = v_r[0];
    e = v_r[4];
    se = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    sa = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    ch = (e & v_r[5]) ^ (~e & v_r[6]);
    mj = (a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1 = v_r[7] + se + ch + sha_pkg::K[rnd_r] + wt;
    t2 = sa + mj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      rnd_r  <= '0;
      len_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::IV[i];
    end else begin
      if (cmd.init) begin
        len_r <= '0;
        for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::IV[i];
      end else if (cmd.len_add) begin
        len_r <= len_r + {58'd0, nb, 3'd0};
      end
      if (cmd.load) begin
        w_r[widx_r] <= ld_word;
        widx_r <= widx_r + 4'd1;
      end
      if (cmd.rehash) begin
        for (int i = 0; i < 8; i++) w_r[i] <= h_r[i];
        widx_r <= 4'd8;
        len_r  <= 64'd256;
        for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::IV[i];
      end
      if (cmd.start) begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        rnd_r <= '0;
      end
      if (cmd.round) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wnew;
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  assign rd_word  = h_r[rd_idx];
  assign sts.widx = widx_r;
  assign sts.rnd  = rnd_r;

endmodule

@@ src/sha_ctrl.sv @@
// SHA-256 controller: accepts words, sequences padding, rounds and digest output.
module sha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_double_hash,
  input  logic            in_valid,
  input  logic            in_last,
  input  logic [2:0]      in_nb,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [2:0]      out_idx,
  output sha_pkg::cmd_t   cmd,
  input  sha_pkg::sts_t   sts
);

  typedef enum logic [2:0] {
    S_IN, S_RUN, S_FOLD, S_PAD, S_REHASH, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic       fin_r, fin_nxt;       // length words go into the current block
  logic       padded_r, padded_nxt; // 0x80 byte already placed
  logic       pend_r, pend_nxt;     // message ended, padding not finished
  logic       dbl_r, dbl_nxt;
  logic       pass2_r, pass2_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic       acc;

  assign in_ready  = (state_r == S_IN);
  assign out_valid = (state_r == S_OUT);
  assign out_idx   = oidx_r;
  assign acc       = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    padded_nxt = padded_r;
    pend_nxt   = pend_r;
    dbl_nxt    = dbl_r;
    pass2_nxt  = pass2_r;
    oidx_nxt   = oidx_r;
    cmd        = '0;
    cmd.ld_sel = sha_pkg::LD_MSG;
    unique case (state_r)
      S_IN: if (acc) begin
        cmd.load    = 1'b1;
        cmd.len_add = 1'b1;
        fin_nxt     = 1'b0;
        if (in_last) begin
          dbl_nxt    = cfg_double_hash;
          pend_nxt   = 1'b1;
          // a full last word leaves the 0x80 byte for the next slot
          padded_nxt = (in_nb < 3'd4);
          // length fits only if the 0x80 byte sits in slot 13 or lower
          fin_nxt    = (in_nb < 3'd4) && (sts.widx <= 4'd13);
          state_nxt  = S_PAD;
        end
        if (sts.widx == 4'd15) begin
          cmd.start = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_PAD: begin
        cmd.load = 1'b1;
        if (!padded_r) begin
          cmd.ld_sel = sha_pkg::LD_PAD;
          padded_nxt = 1'b1;
          fin_nxt    = (sts.widx <= 4'd13);
        end else if (fin_r && sts.widx >= 4'd14) begin
          cmd.ld_sel = sha_pkg::LD_LEN;
        end else begin
          cmd.ld_sel = sha_pkg::LD_ZERO;
        end
        if (sts.widx == 4'd15) begin
          cmd.start = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.round = 1'b1;
        if (sts.rnd == 6'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (fin_r) begin
          if (dbl_r && !pass2_r) state_nxt = S_REHASH;
          else begin
            oidx_nxt  = '0;
            state_nxt = S_OUT;
          end
        end else if (pend_r) begin
          // message ended in this block; a placed 0x80 leaves room for length next
          fin_nxt   = padded_r;
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IN;
        end
      end
      S_REHASH: begin
        cmd.rehash = 1'b1;
        pass2_nxt  = 1'b1;
        padded_nxt = 1'b0;
        state_nxt  = S_PAD;
      end
      S_OUT: if (out_ready) begin
        oidx_nxt = oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          cmd.init   = 1'b1;
          pass2_nxt  = 1'b0;
          fin_nxt    = 1'b0;
          padded_nxt = 1'b0;
          pend_nxt   = 1'b0;
          state_nxt  = S_IN;
        end
      end
      default: state_nxt = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IN;
      fin_r    <= 1'b0;
      padded_r <= 1'b0;
      pend_r   <= 1'b0;
      dbl_r    <= 1'b0;
      pass2_r  <= 1'b0;
      oidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      fin_r    <= fin_nxt;
      padded_r <= padded_nxt;
      pend_r   <= pend_nxt;
      dbl_r    <= dbl_nxt;
      pass2_r  <= pass2_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  a_out_idx_zero_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOLD && state_nxt == S_OUT) |=> (oidx_r == 3'd0))
    else $error("digest index not reset");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> !in_ready)
    else $error("ready while rounds run");
  a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && sts.rnd == 6'd63) |=> (state_r == S_FOLD))
    else $error("round loop overran");

endmodule

@@ src/sha256_message_hasher_top.sv @@
// Top level of the SHA-256 message hasher.
// Throughput: one word per cycle while a block fills; the 16th word starts 64 rounds
//   and a fold, during which no new word is accepted.
// A last word adds up to 17 padding loads and one or two compressions;
//   double mode adds a rehash step, 8 loads and one more compression; then 8 digest items.
// Reset (rst_n low, synchronous) loads the initial hash and clears control.
module sha256_message_hasher_top (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  sha_pkg::cmd_t cmd;
  sha_pkg::sts_t sts;
  logic          dbl_r;
  logic [2:0]    oidx;

  // Single mode bit, sampled by the controller when the last word arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) dbl_r <= 1'b0;
    else if (cfg_we) dbl_r <= cfg_wdata;
  end

  sha_ctrl u_ctrl (
    .clk, .rst_n,
    .cfg_double_hash (dbl_r),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_word),
    .in_nb     (in_ch.valid_bytes),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_idx   (oidx),
    .cmd, .sts
  );

  sha_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_word (in_ch.data_word),
    .in_nb   (in_ch.last_word ? in_ch.valid_bytes : 3'd4),
    .rd_idx  (oidx),
    .rd_word (out_ch.digest_word),
    .sts
  );

  assign out_ch.digest_index = oidx;
  assign out_ch.digest_last  = (oidx == 3'd7);

endmodule
